/* rtl/lfps_pkg.sv */
package lfps_pkg;

  localparam int unsigned SensorW  = 8;
  localparam int unsigned KpW      = 16;
  localparam int unsigned KdW      = 4;
  localparam int unsigned SpeedW   = 8;
  localparam int unsigned StepW    = 6;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned ErrW     = 13;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned DivW      = 16;
  localparam int unsigned RemW      = 4;
  localparam int unsigned DivCycles = DivW / 2;
  localparam int unsigned DivCntW   = $clog2(DivCycles);

  localparam logic [CfgIdxW-1:0] CfgKp   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKd   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBase = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMax  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStep = 3'd4;

  localparam logic [KpW-1:0]    KpReset   = 16'd2150;
  localparam logic [KdW-1:0]    KdReset   = 4'd1;
  localparam logic [SpeedW-1:0] BaseReset = 8'd115;
  localparam logic [SpeedW-1:0] MaxReset  = 8'd115;
  localparam logic [StepW-1:0]  StepReset = 6'd5;

  localparam logic signed [ErrW:0] CenterPos     = 14'sd3500;
  localparam logic [DivW-1:0]      SensorSpacing = 16'd1000;
  localparam logic [SensorW-1:0]   ExitPattern   = 8'h18;

  typedef enum logic [ModeW-1:0] {
    ModeTrack = 2'd0,
    ModeLeft  = 2'd1,
    ModeRight = 2'd2
  } drive_mode_e;

  typedef enum logic [2:0] {
    StIdle,
    StDecide,
    StDiv,
    StErr,
    StMul,
    StSum,
    StEmit
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic enter_left;
    logic enter_right;
    logic emit_turn;
    logic div_step;
    logic err_calc;
    logic mul;
    logic sum;
    logic emit_pd;
  } dp_cmd_t;

  typedef struct packed {
    logic in_turn;
    logic left_hit;
    logic right_hit;
    logic empty;
    logic slot_free;
  } dp_status_t;

endpackage

/* rtl/lfps_sample_if.sv */
interface lfps_sample_if;
  import lfps_pkg::*;

  logic               valid;
  logic               ready;
  logic [SensorW-1:0] sensor_bits;

  modport source (output valid, output sensor_bits, input ready);
  modport sink (input valid, input sensor_bits, output ready);
endinterface

/* rtl/lfps_duty_if.sv */
interface lfps_duty_if;
  import lfps_pkg::*;

  logic              valid;
  logic              ready;
  logic [SpeedW-1:0] left_duty;
  logic [SpeedW-1:0] right_duty;
  logic [ModeW-1:0]  drive_mode;

  modport source (output valid, output left_duty, output right_duty, output drive_mode,
                  input ready);
  modport sink (input valid, input left_duty, input right_duty, input drive_mode,
                output ready);
endinterface

/* rtl/lfps_ctrl.sv */
module lfps_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lfps_pkg::dp_status_t status_i,
  output lfps_pkg::dp_cmd_t    cmd_o
);
  import lfps_pkg::*;

  ctrl_state_e        state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDecide;
        end
      end
      StDecide: begin
        priority if (status_i.in_turn) begin
          if (status_i.slot_free) begin
            cmd_o.emit_turn = 1'b1;
            state_d         = StIdle;
          end
        end else if (status_i.left_hit) begin
          cmd_o.enter_left = 1'b1;
          state_d          = StIdle;
        end else if (status_i.right_hit) begin
          cmd_o.enter_right = 1'b1;
          state_d           = StIdle;
        end else if (status_i.empty) begin
          state_d = StIdle;
        end else begin
          cnt_d   = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivCycles - 1)) begin
          state_d = StErr;
        end
      end
      StErr: begin
        cmd_o.err_calc = 1'b1;
        state_d        = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StSum;
      end
      StSum: begin
        cmd_o.sum = 1'b1;
        state_d   = StEmit;
      end
      StEmit: begin
        if (status_i.slot_free) begin
          cmd_o.emit_pd = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

/* rtl/lfps_dp.sv */
module lfps_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [lfps_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [lfps_pkg::CfgDataW-1:0]          cfg_data_i,
  input  logic [lfps_pkg::SensorW-1:0]           sensor_bits_i,
  input  lfps_pkg::dp_cmd_t                      cmd_i,
  output lfps_pkg::dp_status_t                   status_o,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic [lfps_pkg::SpeedW-1:0]            left_duty_o,
  output logic [lfps_pkg::SpeedW-1:0]            right_duty_o,
  output logic [lfps_pkg::ModeW-1:0]             drive_mode_o
);
  import lfps_pkg::*;

  function automatic logic [2:0] count4(input logic [3:0] v);
    logic [2:0] n;
    n = '0;
    for (int i = 0; i < 4; i++) begin
      n = n + 3'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [RemW:0] div_bit(input logic [RemW-1:0] rem, input logic din,
                                            input logic [RemW-1:0] dvs);
    logic [RemW:0] r2;
    logic [RemW:0] diff;
    r2   = {rem, din};
    diff = r2 - {1'b0, dvs};
    if (r2 >= {1'b0, dvs}) begin
      return {1'b1, diff[RemW-1:0]};
    end
    return {1'b0, r2[RemW-1:0]};
  endfunction

  function automatic logic [SpeedW-1:0] turn_duty(input logic [SpeedW-1:0] max_v,
                                                  input logic [StepW-1:0] step_v,
                                                  input logic [2:0] outer);
    logic [1:0]        n;
    logic [SpeedW-1:0] cut;
    n   = 2'(outer[0]) + 2'(outer[1]) + 2'(outer[2]);
    cut = {2'b00, step_v} * {6'b0, n};
    if (cut > max_v) begin
      return '0;
    end
    return max_v - cut;
  endfunction

  function automatic logic [SpeedW-1:0] clamp_duty(input logic signed [20:0] v,
                                                   input logic [SpeedW-1:0] max_v);
    if (v < 0) begin
      return '0;
    end
    if (v > $signed({13'b0, max_v})) begin
      return max_v;
    end
    return v[SpeedW-1:0];
  endfunction

  logic [KpW-1:0]    kp_q;
  logic [KdW-1:0]    kd_q;
  logic [SpeedW-1:0] base_q;
  logic [SpeedW-1:0] max_q;
  logic [StepW-1:0]  step_q;

  drive_mode_e              mode_q;
  logic signed [ErrW-1:0]   prev_err_q;
  logic                     out_valid_q;

  logic [SensorW-1:0]       sample_q;
  logic [DivW-1:0]          quo_q, quo_d;
  logic [RemW-1:0]          rem_q, rem_d;
  logic [RemW-1:0]          dvs_q;
  logic signed [ErrW-1:0]   err_q, err_d;
  logic signed [ErrW:0]     diff_q, diff_d;
  logic signed [29:0]       pkp_q, pkp_d;
  logic signed [18:0]       pkd_q, pkd_d;
  logic signed [19:0]       ctl_q, ctl_d;
  logic [SpeedW-1:0]        left_q, right_q;
  logic [ModeW-1:0]         dmode_q;

  logic [4:0]               wsum;
  logic [DivW-1:0]          dividend;
  logic [2:0]               lc, rc;
  logic [RemW:0]            s1, s2;
  logic signed [ErrW:0]     err_wide;
  logic signed [35:0]       c_sum, c_adj;
  logic signed [20:0]       ctl_ext;
  logic signed [20:0]       base_ext;
  logic                     slot_free;

  always_comb begin
    wsum = '0;
    for (int b = 0; b < SensorW; b++) begin
      if (sensor_bits_i[b]) begin
        wsum = wsum + 5'(SensorW - 1 - b);
      end
    end
    dividend = 16'(wsum) * SensorSpacing;
  end

  assign lc = count4(sample_q[7:4]);
  assign rc = count4(sample_q[3:0]);

  assign slot_free = !out_valid_q || out_ready_i;

  assign status_o.in_turn   = (mode_q == ModeLeft) || (mode_q == ModeRight);
  assign status_o.left_hit  = (lc >= 3'd3) && (rc <= 3'd2);
  assign status_o.right_hit = (rc >= 3'd3) && (lc <= 3'd2);
  assign status_o.empty     = (sample_q == '0);
  assign status_o.slot_free = slot_free;

  always_comb begin
    s1    = div_bit(rem_q, quo_q[DivW-1], dvs_q);
    s2    = div_bit(s1[RemW-1:0], quo_q[DivW-2], dvs_q);
    quo_d = {quo_q[DivW-3:0], s1[RemW], s2[RemW]};
    rem_d = s2[RemW-1:0];
  end

  always_comb begin
    err_wide = CenterPos - $signed({1'b0, quo_q[ErrW-1:0]});
    err_d    = err_wide[ErrW-1:0];
    diff_d   = {err_d[ErrW-1], err_d} - {prev_err_q[ErrW-1], prev_err_q};
    pkp_d    = 30'($signed({1'b0, kp_q})) * 30'(err_q);
    pkd_d    = 19'($signed({1'b0, kd_q})) * 19'(diff_q);
    c_sum    = 36'(pkp_q) + (36'(pkd_q) <<< 16);
    c_adj    = c_sum + (c_sum[35] ? 36'sd65535 : 36'sd0);
    ctl_d    = c_adj[35:16];
    ctl_ext  = {ctl_q[19], ctl_q};
    base_ext = $signed({13'b0, base_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= KpReset;
      kd_q   <= KdReset;
      base_q <= BaseReset;
      max_q  <= MaxReset;
      step_q <= StepReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgKp:   kp_q   <= cfg_data_i[KpW-1:0];
        CfgKd:   kd_q   <= cfg_data_i[KdW-1:0];
        CfgBase: base_q <= cfg_data_i[SpeedW-1:0];
        CfgMax:  max_q  <= cfg_data_i[SpeedW-1:0];
        CfgStep: step_q <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeTrack;
      prev_err_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.enter_left) begin
        mode_q <= ModeLeft;
      end else if (cmd_i.enter_right) begin
        mode_q <= ModeRight;
      end else if (cmd_i.emit_turn && sample_q == ExitPattern) begin
        mode_q <= ModeTrack;
      end
      if (cmd_i.emit_pd) begin
        prev_err_q <= err_q;
      end
      if (cmd_i.emit_turn || cmd_i.emit_pd) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sensor_bits_i;
      quo_q    <= dividend;
      rem_q    <= '0;
      dvs_q    <= 4'(count4(sensor_bits_i[7:4])) + 4'(count4(sensor_bits_i[3:0]));
    end else if (cmd_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (cmd_i.err_calc) begin
      err_q  <= err_d;
      diff_q <= diff_d;
    end
    if (cmd_i.mul) begin
      pkp_q <= pkp_d;
      pkd_q <= pkd_d;
    end
    if (cmd_i.sum) begin
      ctl_q <= ctl_d;
    end
    if (cmd_i.emit_turn) begin
      if (mode_q == ModeLeft) begin
        left_q  <= '0;
        right_q <= turn_duty(max_q, step_q, sample_q[7:5]);
      end else begin
        left_q  <= turn_duty(max_q, step_q, sample_q[2:0]);
        right_q <= '0;
      end
      dmode_q <= mode_q;
    end else if (cmd_i.emit_pd) begin
      left_q  <= clamp_duty(base_ext - ctl_ext, max_q);
      right_q <= clamp_duty(base_ext + ctl_ext, max_q);
      dmode_q <= ModeTrack;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign left_duty_o  = left_q;
  assign right_duty_o = right_q;
  assign drive_mode_o = dmode_q;

endmodule

/* rtl/line_follower_pd_steering.sv */
// PD steering for an eight-sensor line follower. Each sample transfer is either
// taken as the start of a sharp turn (no result), ignored when no sensor sees the
// line, or turned into a pair of motor duties; in a sharp turn every sample gives
// a result, and the centred sample 0x18 ends the turn. A tracking sample goes from
// its transfer through a decide step, eight passes of the two-bit-per-cycle
// position divider, then error, multiply and sum stages, to the output write.
// A turn sample is written to the output register from its decide step, and
// turn-entry and empty samples also end at the decide step.
// One sample is in work at a time; a held output stalls only a sample that has
// reached its last step. Registers: 0 kp (Q16), 1 kd, 2 base duty, 3 max duty,
// 4 turn step; write them only while the block is idle.
module line_follower_pd_steering (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lfps_sample_if.sink                   sample_if,
  lfps_duty_if.source                   duty_if,
  input  logic                          cfg_we_i,
  input  logic [lfps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lfps_pkg::CfgDataW-1:0] cfg_data_i
);
  import lfps_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  lfps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_if.valid),
    .in_ready_o (sample_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lfps_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .sensor_bits_i (sample_if.sensor_bits),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (duty_if.ready),
    .out_valid_o   (duty_if.valid),
    .left_duty_o   (duty_if.left_duty),
    .right_duty_o  (duty_if.right_duty),
    .drive_mode_o  (duty_if.drive_mode)
  );

endmodule
